// ===== design/cdq_pkg.sv =====
// Shared types and codes for the circular deque.
// Depends on nothing; imported by the interfaces and every module.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned StatusWidth  = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_LIST      = 3'd4
  } cdq_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  typedef struct packed {
    logic        ins_front;
    logic        ins_rear;
    logic        del_front;
    logic        del_rear;
    logic        list_start;
    logic        list_next;
    logic        load;
    cdq_status_e status;
  } cdq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } cdq_stat_t;

endpackage

// ===== design/cdq_in_if.sv =====
// Request channel of the circular deque: operation code and word.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

interface cdq_in_if
  import cdq_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [OpWidth-1:0]          op;
  logic signed [DataWidth-1:0] data;

  modport source (output valid, output op, output data, input ready);
  modport sink   (input valid, input op, input data, output ready);
endinterface

// ===== design/cdq_out_if.sv =====
// Result channel of the circular deque: status, word and last flag.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

interface cdq_out_if
  import cdq_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [StatusWidth-1:0]      status;
  logic signed [DataWidth-1:0] value;
  logic                        last;

  modport source (output valid, output status, output value, output last, input ready);
  modport sink   (input valid, input status, input value, input last, output ready);
endinterface

// ===== design/cdq_datapath.sv =====
// Datapath of the circular deque: word store, pointers and result registers.
// Depends on cdq_pkg; driven by commands from cdq_ctrl.
`timescale 1ns / 1ps

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdq_cmd_t                    cmd_i,
  input  logic signed [DataWidth-1:0] data_i,
  output cdq_stat_t                   stat_o,
  output logic [StatusWidth-1:0]      status_o,
  output logic signed [DataWidth-1:0] value_o,
  output logic                        last_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);

  logic [DataWidth-1:0] mem [DEPTH];
  logic [DataWidth-1:0] rd_q;
  logic [PW-1:0]        head_q, head_d, tail_q, tail_d, idx_q;
  logic                 occ_q, occ_d;
  cdq_status_e          status_q;
  logic                 last_q, use_rd_q;
  logic [PW-1:0]        waddr, raddr;
  logic                 wr_en, rd_en;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] i);
    return (i == LastIdx) ? '0 : i + PW'(1);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] i);
    return (i == '0) ? LastIdx : i - PW'(1);
  endfunction

  assign stat_o.full  = occ_q && (wrap_inc(tail_q) == head_q);
  assign stat_o.empty = !occ_q;
  assign stat_o.last  = last_q;

  assign wr_en = cmd_i.ins_front || cmd_i.ins_rear;
  assign rd_en = cmd_i.del_front || cmd_i.del_rear || cmd_i.list_start || cmd_i.list_next;

  always_comb begin
    if (!occ_q) begin
      waddr = '0;
    end else if (cmd_i.ins_front) begin
      waddr = wrap_dec(head_q);
    end else begin
      waddr = wrap_inc(tail_q);
    end
    if (cmd_i.del_rear) begin
      raddr = tail_q;
    end else if (cmd_i.list_next) begin
      raddr = wrap_inc(idx_q);
    end else begin
      raddr = head_q;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (wr_en) begin
      if (!occ_q) begin
        head_d = '0;
        tail_d = '0;
        occ_d  = 1'b1;
      end else if (cmd_i.ins_front) begin
        head_d = waddr;
      end else begin
        tail_d = waddr;
      end
    end else if (cmd_i.del_front || cmd_i.del_rear) begin
      if (head_q == tail_q) begin
        head_d = '0;
        tail_d = '0;
        occ_d  = 1'b0;
      end else if (cmd_i.del_front) begin
        head_d = wrap_inc(head_q);
      end else begin
        tail_d = wrap_dec(tail_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q  <= mem[raddr];
      idx_q <= raddr;
    end
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      use_rd_q <= cmd_i.del_front || cmd_i.del_rear || cmd_i.list_start;
      last_q   <= cmd_i.list_start ? (head_q == tail_q) : 1'b1;
    end else if (cmd_i.list_next) begin
      last_q   <= (raddr == tail_q);
    end
  end

  assign status_o = status_q;
  assign value_o  = use_rd_q ? rd_q : '0;
  assign last_o   = last_q;

endmodule

// ===== design/cdq_ctrl.sv =====
// Controller of the circular deque: decodes requests, sequences listings.
// Depends on cdq_pkg; commands cdq_datapath.
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpWidth-1:0] op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cdq_stat_t          stat_i,
  output cdq_cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   list_q, list_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    state_d = state_q;
    list_d  = list_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          list_d = 1'b0;
          unique case (op_i) inside
            OP_INS_FRONT, OP_INS_REAR: begin
              state_d   = S_OUT;
              cmd_o.load = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.ins_front = (op_i == OP_INS_FRONT);
                cmd_o.ins_rear  = (op_i == OP_INS_REAR);
              end
            end
            OP_DEL_FRONT, OP_DEL_REAR: begin
              state_d   = S_OUT;
              cmd_o.load = 1'b1;
              if (stat_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.del_front = (op_i == OP_DEL_FRONT);
                cmd_o.del_rear  = (op_i == OP_DEL_REAR);
              end
            end
            OP_LIST: begin
              state_d   = S_OUT;
              cmd_o.load = 1'b1;
              if (stat_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.list_start = 1'b1;
                list_d           = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (list_q && !stat_i.last) begin
            cmd_o.list_next = 1'b1;
          end else begin
            state_d = S_IDLE;
            list_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      list_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      list_q  <= list_d;
    end
  end

endmodule

// ===== design/circular_deque.sv =====
// Circular double-ended queue of DEPTH 32-bit words.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctrl and cdq_datapath.
//
// Usage:
//   in_i carries one request item: op (insert front/rear, delete front/rear,
//   list) and the word to insert. out_o returns result items: status, the
//   removed or listed word, and last on the final result of a request.
//   Insert, delete and refused requests give one result; a listing gives one
//   result per stored word, front to rear; unused op codes give none.
//   The result of a request is valid in the cycle after it is accepted. One
//   request is worked on at a time: a request with one result is accepted,
//   then its result is given; a listing reads the single read port of the
//   word store once per result. Unused op codes are accepted with no result.
//   A stalled receiver holds the result and its successors; in_i.ready stays
//   low until the last result of the current request is taken.
//   Reset empties the deque and clears the pointers; the stored words are not
//   cleared and there is no clearing pass.
`timescale 1ns / 1ps

module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .op_i        (in_i.op),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .data_i   (in_i.data),
    .stat_o   (stat),
    .status_o (out_o.status),
    .value_o  (out_o.value),
    .last_o   (out_o.last)
  );

endmodule

// ===== bench/cdq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the circular deque: mirrors the deque from accepted request
// items and checks every accepted result item in order.
// Depends on cdq_pkg.

module cdq_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [OpWidth-1:0]     req_op_i,
  input  logic [DataWidth-1:0]   req_data_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [StatusWidth-1:0] res_status_i,
  input  logic [DataWidth-1:0]   res_value_i,
  input  logic                   res_last_i,
  output int unsigned            due_count_o,
  output int unsigned            fail_count_o
);

  typedef struct packed {
    cdq_status_e          status;
    logic [DataWidth-1:0] value;
    logic                 last;
  } deque_result_t;

  logic [DataWidth-1:0] words [DEPTH];
  int unsigned          front_idx;
  int unsigned          rear_idx;
  logic                 holding;
  deque_result_t        due_results [$];
  deque_result_t        want;

  function automatic int unsigned wrap_up(input int unsigned idx);
    return (idx + 1) % DEPTH;
  endfunction

  function automatic int unsigned wrap_down(input int unsigned idx);
    return (idx + DEPTH - 1) % DEPTH;
  endfunction

  task automatic queue_result(input cdq_status_e status, input logic [DataWidth-1:0] value,
                              input logic last);
    deque_result_t item;
    item.status = status;
    item.value  = value;
    item.last   = last;
    due_results.push_back(item);
  endtask

  task automatic apply_request(input logic [OpWidth-1:0] op,
                               input logic [DataWidth-1:0] word);
    int unsigned idx;
    int unsigned count;
    case (op)
      OP_INS_FRONT, OP_INS_REAR: begin
        if (holding && wrap_up(rear_idx) == front_idx) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (!holding) begin
            front_idx = 0;
            rear_idx  = 0;
            holding   = 1'b1;
            words[0]  = word;
          end else if (op == OP_INS_FRONT) begin
            front_idx        = wrap_down(front_idx);
            words[front_idx] = word;
          end else begin
            rear_idx        = wrap_up(rear_idx);
            words[rear_idx] = word;
          end
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_REAR: begin
        if (!holding) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else if (front_idx == rear_idx) begin
          queue_result(ST_OK, words[front_idx], 1'b1);
          front_idx = 0;
          rear_idx  = 0;
          holding   = 1'b0;
        end else if (op == OP_DEL_FRONT) begin
          queue_result(ST_OK, words[front_idx], 1'b1);
          front_idx = wrap_up(front_idx);
        end else begin
          queue_result(ST_OK, words[rear_idx], 1'b1);
          rear_idx = wrap_down(rear_idx);
        end
      end
      OP_LIST: begin
        if (!holding) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx   = front_idx;
          count = 0;
          while (idx != rear_idx && count < DEPTH - 1) begin
            queue_result(ST_OK, words[idx], 1'b0);
            idx = wrap_up(idx);
            count++;
          end
          queue_result(ST_OK, words[rear_idx], 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx = 0;
      rear_idx  = 0;
      holding   = 1'b0;
      due_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result item: status %0d value %08h last %0b",
                 res_status_i, res_value_i, res_last_i);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (res_status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_status_i);
            fail_count_o++;
          end
          if (res_value_i !== want.value) begin
            $error("value: expected %08h, got %08h", want.value, res_value_i);
            fail_count_o++;
          end
          if (res_last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_last_i);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        apply_request(req_op_i, req_data_i);
      end
    end
    due_count_o = due_results.size();
  end

endmodule

// ===== bench/circular_deque_tb.sv =====
`timescale 1ns / 1ps
// Top of the circular deque bench: clock, reset, request and result traffic
// with random gaps, and the verdict. Depends on cdq_pkg, the two channel
// interfaces, circular_deque and cdq_checker.

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned DrainCycles = 4;

  localparam logic [OpWidth-1:0] OpSpareFirst = OpWidth'(OP_LIST) + 1'b1;
  localparam logic [OpWidth-1:0] OpSpareLast  = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  logic        hold_req;
  logic        hold_done;
  int unsigned due_count;
  int unsigned fail_count;
  int unsigned idle_cycles;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque #(
    .DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  cdq_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_ch.valid),
    .req_ready_i (in_ch.ready),
    .req_op_i    (in_ch.op),
    .req_data_i  (in_ch.data),
    .res_valid_i (out_ch.valid),
    .res_ready_i (out_ch.ready),
    .res_status_i(out_ch.status),
    .res_value_i (out_ch.value),
    .res_last_i  (out_ch.last),
    .due_count_o (due_count),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OpWidth-1:0] pick_op(input logic filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OpWidth'($urandom_range(OpSpareFirst, OpSpareLast));
    if (r < 10) return OP_LIST;
    if (r < 75) begin
      if (filling) return (r % 2) ? OP_INS_FRONT : OP_INS_REAR;
      return (r % 2) ? OP_DEL_FRONT : OP_DEL_REAR;
    end
    if (filling) return (r % 2) ? OP_DEL_FRONT : OP_DEL_REAR;
    return (r % 2) ? OP_INS_FRONT : OP_INS_REAR;
  endfunction

  function automatic logic [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] word);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.data  <= word;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  initial begin
    logic filling;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_INS_FRONT;
    in_ch.data  <= '0;
    rst_ni      <= 1'b0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    filling   = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(OP_DEL_FRONT, 32'hDEAD_BEEF);
    send_request(OP_DEL_REAR, '1);
    send_request(OP_LIST, '0);
    send_request(OP_INS_REAR, 32'h7FFF_FFFF);
    send_request(OP_INS_FRONT, 32'h8000_0000);
    send_request(OP_INS_REAR, '0);
    send_request(OP_INS_FRONT, '1);
    send_request(OP_LIST, '0);
    send_request(OpSpareFirst, $urandom());
    send_request(OpSpareLast, $urandom());
    repeat (Depth - 4) send_request($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR,
                                    $urandom());
    send_request(OP_INS_FRONT, 32'h5555_5555);
    send_request(OP_INS_REAR, 32'hAAAA_AAAA);
    send_request(OP_LIST, '0);
    repeat (Depth) send_request($urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR, '0);
    send_request(OP_DEL_REAR, '0);

    for (int i = 0; i < RandomItems; i++) begin
      if (i != 0 && i % 20 == 0) filling = !filling;
      steady = ((i / 40) % 3 == 2);
      if (i == 120) hold_req = 1'b1;
      send_request(pick_op(filling), pick_word());
    end
    in_ch.valid <= 1'b0;

    @(negedge clk_i);
    while (due_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
